// ===== design/quadrature_detent_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Quadrature detent decoder assertion macros
// Shared concurrent assertion forms; expect clk and arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef QUADRATURE_DETENT_DECODER_MACROS_SVH
`define QUADRATURE_DETENT_DECODER_MACROS_SVH

// same-cycle implication
`define QDD_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define QDD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/qdd_pkg.sv =====
// ----------------------------------------------------------------------------
// qdd_pkg
// Types, register indexes and phase helpers for the detent decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package qdd_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_SKIP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_DETENT = 2'd1;

	localparam logic [7:0] SAMPLE_SKIP_RESET = 8'd3;
	localparam logic [3:0] STEPS_PER_DETENT_RESET = 4'd4;

	localparam logic [2:0] PHASE_NONE = 3'd0;
	localparam logic [2:0] PHASE_DETENT = 3'd1;

	typedef struct packed {
		logic       fwd;
		logic       rev;
		logic [2:0] phase;
	} result_t;

	// AB = 11 -> 1, 01 -> 2, 00 -> 3, 10 -> 4
	function automatic logic [2:0] pins_to_phase(input logic a, input logic b);
		logic [2:0] p;
		if (a) begin
			p = b ? 3'd1 : 3'd4;
		end else begin
			p = b ? 3'd2 : 3'd3;
		end
		return p;
	endfunction

	// 1->2 ... 4->1
	function automatic logic [2:0] phase_next(input logic [2:0] p);
		return {1'b0, p[1:0]} + 3'd1;
	endfunction

	// 1->4 ... 4->3
	function automatic logic [2:0] phase_prev(input logic [2:0] p);
		logic [1:0] t;
		t = p[1:0] + 2'd2;
		return {1'b0, t} + 3'd1;
	endfunction

endpackage

`default_nettype wire

// ===== design/qdd_core.sv =====
// ----------------------------------------------------------------------------
// qdd_core
// Prescaler, debounce, phase tracking and detent counters; one tick per cycle while accept is high.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrature_detent_decoder_macros.svh"

module qdd_core
	import qdd_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                 accept,
	input  wire logic                 pin_a,
	input  wire logic                 pin_b,
	output result_t                   res
);

	logic [7:0] sample_skip_q;
	logic [3:0] steps_per_detent_q;
	logic [7:0] tick_q;
	logic [2:0] prev_sample_q;
	logic [2:0] phase_q;
	logic       seeded_q;
	logic [7:0] fwd_steps_q;
	logic [7:0] rev_steps_q;

	logic [7:0] tick_d;
	logic [2:0] prev_sample_d;
	logic [2:0] phase_d;
	logic       seeded_d;
	logic [7:0] fwd_steps_d;
	logic [7:0] rev_steps_d;

	logic       sample;
	logic       stable;
	logic [2:0] s;
	logic [2:0] cur;
	logic       fwd_hit;
	logic       rev_hit;
	logic       step_fwd;
	logic       step_rev;
	logic [7:0] fwd_base;
	logic [7:0] rev_base;

	always_comb begin
		sample   = tick_q >= sample_skip_q;
		s        = pins_to_phase(pin_a, pin_b);
		stable   = sample && (s == prev_sample_q);
		cur      = seeded_q ? phase_q : s;
		fwd_hit  = stable && (cur == PHASE_DETENT) && (fwd_steps_q >= {4'd0, steps_per_detent_q});
		rev_hit  = stable && (cur == PHASE_DETENT) && (rev_steps_q >= {4'd0, steps_per_detent_q});
		step_fwd = stable && (cur != PHASE_NONE) && (s == phase_next(cur));
		step_rev = stable && (cur != PHASE_NONE) && !step_fwd && (s == phase_prev(cur));
		fwd_base = fwd_hit ? 8'd0 : fwd_steps_q;
		rev_base = rev_hit ? 8'd0 : rev_steps_q;

		tick_d        = sample ? 8'd0 : tick_q + 8'd1;
		prev_sample_d = sample ? s : prev_sample_q;
		seeded_d      = seeded_q | stable;
		phase_d       = stable ? ((step_fwd || step_rev) ? s : cur) : phase_q;
		fwd_steps_d   = fwd_base + {7'd0, step_fwd};
		rev_steps_d   = rev_base + {7'd0, step_rev};

		res.fwd   = fwd_hit;
		res.rev   = rev_hit;
		res.phase = phase_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_skip_q      <= SAMPLE_SKIP_RESET;
			steps_per_detent_q <= STEPS_PER_DETENT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SAMPLE_SKIP:      sample_skip_q <= cfg_wdata;
				REG_STEPS_PER_DETENT: steps_per_detent_q <= cfg_wdata[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q        <= '0;
			prev_sample_q <= PHASE_NONE;
			phase_q       <= PHASE_NONE;
			seeded_q      <= 1'b0;
			fwd_steps_q   <= '0;
			rev_steps_q   <= '0;
		end else if (accept) begin
			tick_q        <= tick_d;
			prev_sample_q <= prev_sample_d;
			phase_q       <= phase_d;
			seeded_q      <= seeded_d;
			fwd_steps_q   <= fwd_steps_d;
			rev_steps_q   <= rev_steps_d;
		end
	end

	`QDD_ASSERT_IMPL(a_unseeded_phase, !seeded_q, phase_q == PHASE_NONE, "phase set before seeding")
	`QDD_ASSERT_IMPL(a_seeded_phase, seeded_q, phase_q != PHASE_NONE && phase_q <= 3'd4, "tracked phase out of range")
	`QDD_ASSERT_NEXT(a_detent_on_sample, accept && (res.fwd || res.rev), tick_q == 8'd0, "detent without a sample")

endmodule

`default_nettype wire

// ===== design/qdd_out_buf.sv =====
// ----------------------------------------------------------------------------
// qdd_out_buf
// Result register plus skid entry; decouples input ready from output ready.
// ----------------------------------------------------------------------------
`default_nettype none
`include "quadrature_detent_decoder_macros.svh"

module qdd_out_buf
	import qdd_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         can_push,
	output logic         out_valid,
	input  wire logic    out_ready,
	output result_t      out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_data_q;
	result_t skid_data_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign can_push  = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= push;
			end else begin
				main_valid_q <= push;
			end
		end else if (!main_valid_q) begin
			main_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_data_q <= skid_data_q;
				skid_data_q <= push_data;
			end else begin
				main_data_q <= push_data;
			end
		end else if (!main_valid_q) begin
			main_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

	`QDD_ASSERT_IMPL(a_skid_implies_main, skid_valid_q, main_valid_q, "skid holds item with empty result register")
	`QDD_ASSERT_NEXT(a_skid_holds, skid_valid_q && !pop, skid_valid_q && $stable(skid_data_q), "skid item lost")
	`QDD_ASSERT_NEXT(a_main_holds, main_valid_q && !pop, main_valid_q && $stable(main_data_q), "result changed while waiting")

endmodule

`default_nettype wire

// ===== design/quadrature_detent_decoder.sv =====
// ----------------------------------------------------------------------------
// quadrature_detent_decoder
// Rotary encoder decoder with prescaled sampling, debounce and detent flags.
// ----------------------------------------------------------------------------
// Each input item is one tick with the A/B pin levels. Every (sample_skip+1)th
// tick samples the pins, maps AB = 11/01/00/10 to phase 1..4 and keeps it only
// if it matches the previous sample. The first kept sample seeds the tracked
// phase; adjacent moves count forward or reverse steps, other jumps are
// dropped. When a kept sample finds the tracked phase at 1, a step counter at
// or above steps_per_detent clears and raises its one-tick detent flag. Every
// tick yields exactly one result item. Throughput is one item per clock while
// the skid entry is free: the state update is a single pass of logic between
// the tick state registers and a result register, and a one-entry skid lets
// one more item in after the output stalls. An accepted item is registered
// into the result register, or into the skid while it is held. Configuration:
// index 0 = sample_skip (8 bits, reset 3), index 1 = steps_per_detent (low 4
// bits, reset 4); other indexes are ignored. Write config only while idle.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_detent_decoder
	import qdd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  pin_a,
	input  wire logic                  pin_b,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       forward_detent,
	output logic                       reverse_detent,
	output logic [2:0]                 tracked_phase
);

	logic    accept;
	result_t core_res;
	result_t out_data;

	// item enters when the skid entry is free
	assign accept = in_valid && in_ready;

	qdd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.accept    (accept),
		.pin_a     (pin_a),
		.pin_b     (pin_b),
		.res       (core_res)
	);

	qdd_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (core_res),
		.can_push  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	assign forward_detent = out_data.fwd;
	assign reverse_detent = out_data.rev;
	assign tracked_phase  = out_data.phase;

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// Quadrature detent decoder testbench
// Streams encoder pin ticks through the decoder under random sender bursts
// and receiver stalls. A scoreboard tracks prescaler, debounce, phase and
// step counters per accepted tick and checks every result item in order.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	import qdd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 1000;   // cycles with no item moving either way
	localparam int DRAIN_CYCLES = 6;     // result register plus skid, with margin
	localparam int HOLD_CAP = 280;       // longest run of one pin level
	localparam int LONG_HOLD = 80;       // receiver hold-off length
	localparam int LONG_HOLD_AT = 300;   // accepted ticks before the hold-off

	// Indexes the block does not decode; writes there must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	// Scoreboard: models the decoder per accepted tick and holds the expected
	// result items until the block delivers them.
	class detent_scoreboard;
		logic [7:0] skip_reg;
		logic [3:0] detent_reg;
		logic [7:0] prescale;
		logic [2:0] last_sample;
		logic [2:0] phase;
		bit         locked;
		logic [7:0] fwd_count;
		logic [7:0] rev_count;
		result_t    expected_ticks[$];
		int         errors;
		int         accepted;
		int         checked;

		function new();
			skip_reg = SAMPLE_SKIP_RESET;
			detent_reg = STEPS_PER_DETENT_RESET;
			prescale = '0;
			last_sample = PHASE_NONE;
			phase = PHASE_NONE;
			locked = 1'b0;
			fwd_count = '0;
			rev_count = '0;
			errors = 0;
			accepted = 0;
			checked = 0;
		endfunction

		static function logic [2:0] ring_next(logic [2:0] p);
			return (p == 3'd4) ? 3'd1 : p + 3'd1;
		endfunction

		static function logic [2:0] ring_prev(logic [2:0] p);
			return (p == 3'd1) ? 3'd4 : p - 3'd1;
		endfunction

		static function logic [2:0] phase_of(logic a, logic b);
			case ({a, b})
				2'b11: return 3'd1;
				2'b01: return 3'd2;
				2'b00: return 3'd3;
				default: return 3'd4;
			endcase
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_SAMPLE_SKIP: skip_reg = data;
				REG_STEPS_PER_DETENT: detent_reg = data[3:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_ticks.size();
		endfunction

		function void note_tick(logic a, logic b);
			result_t    r;
			logic [2:0] s;
			r.fwd = 1'b0;
			r.rev = 1'b0;
			accepted++;
			if (prescale < skip_reg) begin
				prescale++;
			end else begin
				s = phase_of(a, b);
				prescale = '0;
				// debounce: only a repeat of the last sample counts
				if (s == last_sample) begin
					if (!locked) begin
						locked = 1'b1;
						phase = s;
					end
					// detent check uses the phase before this sample moves it
					if (phase == PHASE_DETENT) begin
						if (fwd_count >= {4'd0, detent_reg}) begin
							fwd_count = '0;
							r.fwd = 1'b1;
						end
						if (rev_count >= {4'd0, detent_reg}) begin
							rev_count = '0;
							r.rev = 1'b1;
						end
					end
					if (phase != PHASE_NONE) begin
						if (s == ring_next(phase)) begin
							phase = s;
							fwd_count++;
						end else if (s == ring_prev(phase)) begin
							phase = s;
							rev_count++;
						end
					end
				end
				last_sample = s;
			end
			r.phase = phase;
			expected_ticks.push_back(r);
		endfunction

		function void report(string what, result_t want, logic f, logic rv, logic [2:0] p);
			errors++;
			if (errors <= 10) begin
				$display("[%0t] item %0d %s: expected fwd=%0b rev=%0b phase=%0d, got fwd=%0b rev=%0b phase=%0d",
					$realtime, checked, what, want.fwd, want.rev, want.phase, f, rv, p);
			end
		endfunction

		function void check_result(logic f, logic rv, logic [2:0] p);
			result_t want;
			want = '0;
			if (expected_ticks.size() == 0) begin
				report("with nothing outstanding", want, f, rv, p);
			end else begin
				want = expected_ticks.pop_front();
				if (f !== want.fwd || rv !== want.rev || p !== want.phase) begin
					report("differs", want, f, rv, p);
				end
			end
			checked++;
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic                  pin_a = 1'b0;
	logic                  pin_b = 1'b0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic                  forward_detent;
	logic                  reverse_detent;
	logic [2:0]            tracked_phase;

	detent_scoreboard sb;
	logic [1:0]       tick_q[$];               // pending stimulus, {a, b}
	logic [2:0]       rotor = PHASE_DETENT;    // where the simulated knob sits
	int               stuck = 0;

	quadrature_detent_decoder u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_wdata      (cfg_wdata),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.pin_a          (pin_a),
		.pin_b          (pin_b),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.forward_detent (forward_detent),
		.reverse_detent (reverse_detent),
		.tracked_phase  (tracked_phase)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Monitor: handshakes are sampled at the edge, before the block's own
	// updates land, so input and output ordering is race free.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				sb.note_tick(pin_a, pin_b);
			end
			if (out_valid && out_ready) begin
				sb.check_result(forward_detent, reverse_detent, tracked_phase);
			end
		end
	end

	// Watchdog: any long stretch with no item moving means the block hung.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck <= 0;
		end else begin
			stuck <= stuck + 1;
			if (stuck >= STUCK_LIMIT) begin
				$display("quadrature_detent_decoder: mismatch");
				$finish;
			end
		end
	end

	// Receiver: cycles through stall styles, plus one long hold-off once
	// enough ticks have gone in so the skid fills and in_ready drops.
	initial begin : receiver
		int  mode;
		int  mode_left;
		int  cyc;
		bit  held;
		mode = 0;
		mode_left = 0;
		cyc = 0;
		held = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (!held && sb.accepted >= LONG_HOLD_AT) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD - 1) begin
					@(posedge clk);
					out_ready <= 1'b0;
				end
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 3);
					mode_left = $urandom_range(20, 80);
				end
				mode_left--;
				case (mode)
					0: out_ready <= 1'b1;
					1: out_ready <= $urandom_range(0, 1);
					2: out_ready <= ($urandom_range(0, 3) == 0);
					default: out_ready <= ((cyc % 5) != 0);
				endcase
			end
		end
	end

	function automatic logic [1:0] pins_of(logic [2:0] p);
		case (p)
			3'd1: return 2'b11;
			3'd2: return 2'b01;
			3'd3: return 2'b00;
			default: return 2'b10;
		endcase
	endfunction

	// Hold the knob at one phase for 1..3 sample periods, at most HOLD_CAP ticks;
	// one period is too short for the debounce. Occasionally one tick is a glitch.
	task automatic hold_ticks(logic [2:0] p, int skip);
		int hold;
		int glitch;
		hold = (skip + 1) * $urandom_range(1, 3);
		if (hold > HOLD_CAP) hold = HOLD_CAP;
		glitch = ($urandom_range(0, 5) == 0) ? $urandom_range(0, hold - 1) : -1;
		for (int i = 0; i < hold; i++) begin
			tick_q.push_back((i == glitch) ? 2'($urandom_range(0, 3)) : pins_of(p));
		end
	endtask

	// Mostly well-formed rotation in either direction, some skipped phases
	// (illegal jumps), some pure noise.
	task automatic fill_ticks(int n, int skip);
		int kind;
		int steps;
		bit cw;
		while (tick_q.size() < n) begin
			kind = $urandom_range(0, 99);
			if (kind < 70) begin
				cw = $urandom_range(0, 1);
				steps = $urandom_range(1, 12);
				repeat (steps) begin
					rotor = cw ? detent_scoreboard::ring_next(rotor)
					           : detent_scoreboard::ring_prev(rotor);
					hold_ticks(rotor, skip);
				end
			end else if (kind < 85) begin
				rotor = detent_scoreboard::ring_next(detent_scoreboard::ring_next(rotor));
				hold_ticks(rotor, skip);
			end else begin
				repeat ($urandom_range(1, 10)) tick_q.push_back(2'($urandom_range(0, 3)));
			end
		end
		// trim the last chunk so the run is n ticks long
		while (tick_q.size() > n) void'(tick_q.pop_back());
	endtask

	// Sender: bursts of random length; valid stays up through a burst and
	// only drops for a nonzero gap.
	task automatic send_ticks();
		logic [1:0] t;
		int         burst;
		int         gap;
		burst = $urandom_range(1, 40);
		while (tick_q.size() != 0) begin
			t = tick_q.pop_front();
			in_valid <= 1'b1;
			pin_a <= t[1];
			pin_b <= t[0];
			@(posedge clk);
			while (!in_ready) @(posedge clk);
			burst--;
			if (burst == 0) begin
				gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				if (gap != 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
				burst = $urandom_range(1, 40);
			end
		end
		in_valid <= 1'b0;
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// Wait until every expected result item is back, then let the pipe empty.
	task automatic settle();
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_setting(logic [7:0] skip, logic [7:0] steps_data, int n);
		set_reg(REG_SAMPLE_SKIP, skip);
		set_reg(REG_STEPS_PER_DETENT, steps_data);
		fill_ticks(n, skip);
		send_ticks();
		settle();
	endtask

	initial begin : main
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings (sample every 4th tick): seed at phase 1,
		// then two forward steps.
		repeat (8) tick_q.push_back(2'b11);
		repeat (8) tick_q.push_back(2'b01);
		repeat (8) tick_q.push_back(2'b00);
		send_ticks();
		settle();

		// Every tick sampled, detent after a single step.
		run_setting(8'd0, 8'd1, 90);

		// Upper nibble dropped: steps per detent becomes zero, so every kept
		// sample at phase 1 fires both flags. Undecoded indexes are written too.
		set_reg(REG_SPARE_A, 8'hFF);
		set_reg(REG_SPARE_B, 8'h00);
		run_setting(8'd0, 8'h10, 60);

		run_setting(8'd1, 8'h0F, 90);

		// Slowest prescaler; the next setting then drops skip below the
		// running count.
		run_setting(8'd255, 8'd4, 270);
		run_setting(8'd0, 8'hF2, 90);

		repeat (2) begin
			run_setting(8'($urandom_range(0, 5)), 8'($urandom_range(0, 255)), 60);
		end

		settle();
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("quadrature_detent_decoder: match");
		end else begin
			$display("quadrature_detent_decoder: mismatch");
		end
		$finish;
	end

endmodule

`default_nettype wire
